// ----- sv/nirpd_pkg.sv -----
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Shared types, codes and a helper function of the infrared frame decoder.
// ----------------------------------------------------------------------------
package nirpd_pkg;

    // Input item modes.
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_SEGMENT = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;

    // Result event kinds.
    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_REPEAT  = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY_MASK      = 2'd0;
    localparam logic [1:0] CFG_ONE_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_FRAME_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_RELEASE_DELAY = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] KEY_MASK_RST      = 16'd127;
    localparam logic [15:0] ONE_THRESHOLD_RST = 16'd840;
    localparam logic [15:0] FRAME_TIMEOUT_RST = 16'd5000;
    localparam logic [7:0]  RELEASE_DELAY_RST = 8'd150;

    // Number of gaps in a complete frame.
    localparam logic [5:0] FRAME_GAPS = 6'd32;

    // Classified operation carried from the front end to the back end.
    typedef enum logic [1:0] {
        OP_START,
        OP_GAP,
        OP_MARK,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t  op;
        logic long_gap;
        logic timeout;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] key_value;
    } res_t;

    typedef struct packed {
        logic [15:0] key_mask;
        logic [15:0] one_threshold_us;
        logic [15:0] frame_timeout_us;
        logic [7:0]  release_delay_ms;
    } cfg_t;

    // Gather the code bits selected by the mask and pack them to the low end.
    // Each bit's target position is the number of mask bits below it.
    function automatic logic [15:0] pack_masked(logic [15:0] code, logic [15:0] mask);
        logic [15:0] result;
        logic [15:0] below;
        logic [3:0]  pos;
        result = '0;
        for (int b = 0; b < 16; b++) begin
            below = 16'((17'd1 << b) - 17'd1);
            pos   = 4'($countones(mask & below));
            if (mask[b] && code[b]) begin
                result[pos] = 1'b1;
            end
        end
        return result;
    endfunction

endpackage

// ----- sv/nec_ir_pulse_distance_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// NEC IR pulse-distance decoder unit
// Decodes NEC-style infrared frames from timed level segments into key events.
// ----------------------------------------------------------------------------
// Usage:
// Input beats (mode, level, duration_us) enter through a queue-like port: a
// beat is taken at a clock edge with push high and full low. Frame-start,
// level-segment and millisecond-tick beats are accepted; mode 3 is taken and
// dropped. Results leave through a second queue-like port: while empty is low
// the oldest event (event_kind, key_value) is on the ports, and it is taken at
// an edge with pop high.
// The front end classifies each beat and compares its duration with the one
// threshold and the frame timeout. A short command queue decouples it from
// the back end, which owns the frame and release state and writes at most one
// event per beat into the result queue. One beat per cycle is sustained while
// the consumer keeps popping; an accepted beat is registered in the command
// queue and its event in the result queue before it reaches the ports.
// When the consumer stops popping, the result queue fills, the back end holds
// its command, and full rises once the command queue is also full; no event is
// lost. Reset empties both queues, closes any frame, disarms the release timer
// and restores the configuration registers; via the cfg_valid/cfg_ready port
// (always ready) the user writes them only while the block is idle; unchecked.
// ----------------------------------------------------------------------------
module nec_ir_pulse_distance_decoder_unit
    import nirpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic        level,
    input  logic [15:0] duration_us,
    // Result channel
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  event_kind,
    output logic [15:0] key_value,
    // Configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;

    logic cmd_push;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    cmd_t cmd_in;
    cmd_t cmd_head;

    logic res_push;
    logic res_full;
    res_t res_in;
    res_t res_head;

    // Configuration registers; a beat updates only the addressed register.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_MASK:      cfg_next.key_mask         = cfg_data;
                CFG_ONE_THRESHOLD: cfg_next.one_threshold_us = cfg_data;
                CFG_FRAME_TIMEOUT: cfg_next.frame_timeout_us = cfg_data;
                CFG_RELEASE_DELAY: cfg_next.release_delay_ms = cfg_data[7:0];
                default:           cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_mask         <= KEY_MASK_RST;
            cfg_reg.one_threshold_us <= ONE_THRESHOLD_RST;
            cfg_reg.frame_timeout_us <= FRAME_TIMEOUT_RST;
            cfg_reg.release_delay_ms <= RELEASE_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accepts and classifies input beats.
    nirpd_front u_front (
        .push        (push),
        .full        (full),
        .mode        (mode),
        .level       (level),
        .duration_us (duration_us),
        .cfg         (cfg_reg),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in),
        .cmd_full    (cmd_full)
    );

    // Command queue between the front end and the back end.
    nirpd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_head),
        .empty (cmd_empty)
    );

    // Back end: frame decoding and release timing.
    nirpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Result queue toward the consumer.
    nirpd_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign event_kind = res_head.event_kind;
    assign key_value  = res_head.key_value;

endmodule

// ----- sv/nirpd_fifo.sv -----
// ----------------------------------------------------------------------------
// NEC IR decoder queue
// Small register-based first-in first-out queue with a registered head.
// ----------------------------------------------------------------------------
module nirpd_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- sv/nirpd_front.sv -----
// ----------------------------------------------------------------------------
// NEC IR decoder front end
// Accepts input beats, classifies them and compares durations to thresholds.
// ----------------------------------------------------------------------------
module nirpd_front
    import nirpd_pkg::*;
(
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic        level,
    input  logic [15:0] duration_us,
    input  cfg_t        cfg,
    output logic        cmd_push,
    output cmd_t        cmd,
    input  logic        cmd_full
);

    logic known;

    assign full = cmd_full;

    always_comb
    begin
        known        = 1'b1;
        cmd.op       = OP_TICK;
        cmd.long_gap = (duration_us > cfg.one_threshold_us);
        cmd.timeout  = (duration_us >= cfg.frame_timeout_us);
        case (mode)
            MODE_START:   cmd.op = OP_START;
            MODE_SEGMENT: cmd.op = level ? OP_MARK : OP_GAP;
            MODE_TICK:    cmd.op = OP_TICK;
            default:      known  = 1'b0;
        endcase
        // Beats of the unused mode are accepted and dropped here.
        cmd_push = push && !cmd_full && known;
    end

endmodule

// ----- sv/nirpd_back.sv -----
// ----------------------------------------------------------------------------
// NEC IR decoder back end
// Holds the frame and release state and turns commands into events.
// ----------------------------------------------------------------------------
module nirpd_back
    import nirpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  cmd_t cmd,
    input  logic cmd_empty,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    logic        in_frame_reg, in_frame_next;
    logic [5:0]  gap_count_reg, gap_count_next;
    logic [15:0] code_bits_reg, code_bits_next;
    logic [15:0] inverse_bits_reg, inverse_bits_next;
    logic [7:0]  release_countdown_reg, release_countdown_next;
    logic        release_armed_reg, release_armed_next;
    logic [4:0]  bit_idx;

    assign bit_idx = 5'(gap_count_reg - 6'd1);

    always_comb
    begin
        in_frame_next          = in_frame_reg;
        gap_count_next         = gap_count_reg;
        code_bits_next         = code_bits_reg;
        inverse_bits_next      = inverse_bits_reg;
        release_countdown_next = release_countdown_reg;
        release_armed_next     = release_armed_reg;
        res_push               = 1'b0;
        res                    = '0;
        cmd_pop                = !cmd_empty && !res_full;

        if (cmd_pop)
        begin
            case (cmd.op)
                OP_START:
                begin
                    in_frame_next     = 1'b1;
                    gap_count_next    = '0;
                    code_bits_next    = '0;
                    inverse_bits_next = '0;
                end
                OP_TICK:
                begin
                    if (release_armed_reg)
                    begin
                        if (release_countdown_reg <= 8'd1)
                        begin
                            release_countdown_next = '0;
                            release_armed_next     = 1'b0;
                            res_push               = 1'b1;
                            res.event_kind         = EV_RELEASE;
                        end
                        else
                        begin
                            release_countdown_next = release_countdown_reg - 8'd1;
                        end
                    end
                end
                OP_GAP, OP_MARK:
                begin
                    if (in_frame_reg)
                    begin
                        if (cmd.op == OP_GAP)
                        begin
                            if (gap_count_reg != '0 && cmd.long_gap)
                            begin
                                // Address and inverted address fill the upper bytes,
                                // command and inverted command the lower bytes.
                                if (!bit_idx[3])
                                begin
                                    code_bits_next[{!bit_idx[4], bit_idx[2:0]}] = 1'b1;
                                end
                                else
                                begin
                                    inverse_bits_next[{!bit_idx[4], bit_idx[2:0]}] = 1'b1;
                                end
                            end
                            gap_count_next = gap_count_reg + 6'd1;
                        end
                        if (gap_count_next >= FRAME_GAPS)
                        begin
                            in_frame_next          = 1'b0;
                            release_countdown_next = cfg.release_delay_ms;
                            release_armed_next     = 1'b1;
                            res_push               = 1'b1;
                            res.event_kind         = EV_PRESS;
                            res.key_value          = pack_masked(code_bits_next, cfg.key_mask);
                        end
                        else if (cmd.timeout)
                        begin
                            in_frame_next          = 1'b0;
                            release_countdown_next = cfg.release_delay_ms;
                            release_armed_next     = 1'b1;
                            res_push               = 1'b1;
                            res.event_kind         = EV_REPEAT;
                        end
                    end
                end
                default:
                begin
                    res_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg          <= 1'b0;
            gap_count_reg         <= '0;
            code_bits_reg         <= '0;
            inverse_bits_reg      <= '0;
            release_countdown_reg <= '0;
            release_armed_reg     <= 1'b0;
        end
        else
        begin
            in_frame_reg          <= in_frame_next;
            gap_count_reg         <= gap_count_next;
            code_bits_reg         <= code_bits_next;
            inverse_bits_reg      <= inverse_bits_next;
            release_countdown_reg <= release_countdown_next;
            release_armed_reg     <= release_armed_next;
        end
    end

`ifndef SYNTHESIS
    // An open frame never holds a full set of gaps.
    a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (gap_count_reg < FRAME_GAPS))
        else $error("open frame holds a full gap count");

    // A disarmed release timer always rests at zero.
    a_idle_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        !release_armed_reg |-> (release_countdown_reg == '0))
        else $error("release countdown nonzero while disarmed");

    // A press or repeat closes the frame and arms the release timer.
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res.event_kind == EV_PRESS || res.event_kind == EV_REPEAT))
        |=> (!in_frame_reg && release_armed_reg))
        else $error("frame end did not close frame and arm release");

    // A release event always leaves the timer disarmed.
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.event_kind == EV_RELEASE) |=> !release_armed_reg)
        else $error("release event left timer armed");
`endif

endmodule

// ----- tb/nirpd_event_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NEC IR decoder event checker
// Watches the input, configuration and result channels of the decoder, keeps
// its own model of the frame and release state, and compares every result
// beat with the oldest predicted event.
// ----------------------------------------------------------------------------
module nirpd_event_checker
    import nirpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  mode,
    input  logic        level,
    input  logic [15:0] duration_us,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  event_kind,
    input  logic [15:0] key_value,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    cfg_t        regs;
    logic        frame_open;
    logic [5:0]  gaps_seen;
    logic [15:0] code_word;
    logic [15:0] inverse_word;
    logic [7:0]  release_left;
    logic        release_armed;
    res_t        predicted_events[$];

    // Collects the code bits selected by the mask into the low end of the key.
    function automatic logic [15:0] gather_key(input logic [15:0] code,
                                               input logic [15:0] mask);
        logic [15:0] key_bits;
        int          slot;
        key_bits = '0;
        slot     = 0;
        for (int b = 0; b < 16; b++) begin
            if (mask[b])
            begin
                key_bits[slot] = code[b];
                slot++;
            end
        end
        return key_bits;
    endfunction

    // Advances the decoder state by one accepted input beat and queues the
    // event that the beat produces, if any.
    task automatic decode_beat(input logic [1:0] m, input logic lv, input logic [15:0] dur);
        res_t       ev;
        logic [4:0] bit_idx;
        ev.event_kind = EV_PRESS;
        ev.key_value  = '0;
        case (m)
            MODE_START:
            begin
                frame_open   = 1'b1;
                gaps_seen    = '0;
                code_word    = '0;
                inverse_word = '0;
            end
            MODE_TICK:
            begin
                if (release_armed)
                begin
                    if (release_left <= 8'd1)
                    begin
                        release_left  = '0;
                        release_armed = 1'b0;
                        ev.event_kind = EV_RELEASE;
                        predicted_events.push_back(ev);
                    end
                    else
                    begin
                        release_left = release_left - 8'd1;
                    end
                end
            end
            MODE_SEGMENT:
            begin
                if (frame_open)
                begin
                    if (!lv)
                    begin
                        // The leader gap carries no bit; later long gaps are ones.
                        if (gaps_seen != 6'd0 && dur > regs.one_threshold_us)
                        begin
                            bit_idx = 5'(gaps_seen - 6'd1);
                            if (bit_idx < 5'd8)
                                code_word[bit_idx + 8] = 1'b1;
                            else if (bit_idx < 5'd16)
                                inverse_word[bit_idx] = 1'b1;
                            else if (bit_idx < 5'd24)
                                code_word[bit_idx - 16] = 1'b1;
                            else
                                inverse_word[bit_idx - 24] = 1'b1;
                        end
                        gaps_seen = gaps_seen + 6'd1;
                    end
                    // A full frame wins over a timeout on the same segment.
                    if (gaps_seen >= FRAME_GAPS || dur >= regs.frame_timeout_us)
                    begin
                        if (gaps_seen >= FRAME_GAPS)
                        begin
                            ev.event_kind = EV_PRESS;
                            ev.key_value  = gather_key(code_word, regs.key_mask);
                        end
                        else
                        begin
                            ev.event_kind = EV_REPEAT;
                        end
                        frame_open    = 1'b0;
                        release_left  = regs.release_delay_ms;
                        release_armed = 1'b1;
                        predicted_events.push_back(ev);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            regs.key_mask         = KEY_MASK_RST;
            regs.one_threshold_us = ONE_THRESHOLD_RST;
            regs.frame_timeout_us = FRAME_TIMEOUT_RST;
            regs.release_delay_ms = RELEASE_DELAY_RST;
            frame_open            = 1'b0;
            gaps_seen             = '0;
            code_word             = '0;
            inverse_word          = '0;
            release_left          = '0;
            release_armed         = 1'b0;
            predicted_events.delete();
        end
        else
        begin
            // A result beat leaving now always belongs to an earlier input
            // beat, so it is compared before this edge's input is predicted.
            if (pop && !empty)
            begin
                if (predicted_events.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, got kind %0d key %h",
                             $time, event_kind, key_value);
                end
                else
                begin
                    want = predicted_events.pop_front();
                    if (event_kind !== want.event_kind)
                    begin
                        mismatches++;
                        $display("%0t: event_kind mismatch, expected %0d, got %0d",
                                 $time, want.event_kind, event_kind);
                    end
                    if (key_value !== want.key_value)
                    begin
                        mismatches++;
                        $display("%0t: key_value mismatch, expected %h, got %h",
                                 $time, want.key_value, key_value);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_KEY_MASK:      regs.key_mask         = cfg_data;
                    CFG_ONE_THRESHOLD: regs.one_threshold_us = cfg_data;
                    CFG_FRAME_TIMEOUT: regs.frame_timeout_us = cfg_data;
                    CFG_RELEASE_DELAY: regs.release_delay_ms = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (push && !full)
                decode_beat(mode, level, duration_us);
        end
        outstanding = predicted_events.size();
    end

endmodule

// ----- tb/tb_nec_ir_pulse_distance_decoder_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NEC IR pulse-distance decoder testbench
// Drives frame-start, segment, tick and unused-mode beats into the decoder with random
// gaps on both channels, reprograms the registers between phases, and takes
// its verdict from the event checker that watches the channels.
// ----------------------------------------------------------------------------
module tb_nec_ir_pulse_distance_decoder_unit;
    import nirpd_pkg::*;

    // Mode 3 has no meaning; the decoder takes such beats and drops them.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Stimulus stops once this many meaningful beats have been sent.
    localparam int ITEM_TARGET   = 1300;
    // Beats per register setting before the next phase starts.
    localparam int PHASE_ITEMS   = 130;
    // A result passes the command queue and then the result queue; beats that
    // make no result may still be in the command queue when the last event is
    // out, so settle() waits longer before a register write or the end.
    localparam int SETTLE_CYCLES = 8;
    // A correct run stays well below this limit, even with every beat
    // waiting out the longest gap on both sides.
    localparam int CYCLE_LIMIT   = 400000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  mode;
    logic        level;
    logic [15:0] duration_us;
    logic        empty;
    logic        pop;
    logic [1:0]  event_kind;
    logic [15:0] key_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    int   sent_items  = 0;
    bit   feed_calm   = 1'b0;
    bit   drain_calm  = 1'b0;
    cfg_t live_cfg;

    nec_ir_pulse_distance_decoder_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .level       (level),
        .duration_us (duration_us),
        .empty       (empty),
        .pop         (pop),
        .event_kind  (event_kind),
        .key_value   (key_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // The checker sits beside the decoder and only observes; the count of
    // failed comparisons and the number of events still due come back here.
    nirpd_event_checker event_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .level       (level),
        .duration_us (duration_us),
        .empty       (empty),
        .pop         (pop),
        .event_kind  (event_kind),
        .key_value   (key_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost event ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_nec_ir_pulse_distance_decoder_unit NOT OK");
            $finish;
        end
    end

    // Random duration in [lo, hi]. When the window is empty, which happens
    // under the degenerate register settings, any duration will do.
    function automatic logic [15:0] dur_between(input int lo, input int hi);
        if (hi > 65535)
            hi = 65535;
        if (lo > hi)
            return 16'($urandom_range(65535, 0));
        return 16'($urandom_range(hi, lo));
    endfunction

    // Sends one input beat. The sender first idles for a random number of
    // cycles, except during calm stretches, then holds push until the beat
    // is taken. With no idle push simply stays high into the next beat.
    task automatic send_item(input logic [1:0] m, input logic lv, input logic [15:0] dur);
        int idle;
        if ($urandom_range(39, 0) == 0)
            feed_calm = !feed_calm;
        idle = feed_calm ? 0 : $urandom_range(11, 0);
        if (idle > 0)
        begin
            push <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        push        <= 1'b1;
        mode        <= m;
        level       <= lv;
        duration_us <= dur;
        do
            @(posedge clk);
        while (full);
        if (m != MODE_UNUSED)
            sent_items++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(MODE_TICK, 1'($urandom_range(1, 0)),
                                 16'($urandom_range(65535, 0)));
    endtask

    // Sends mark and gap segment pairs of a frame under the live settings.
    // The first gap is the leader and carries no bit; later gaps are short
    // or long at random. The last gap can be stretched past the timeout.
    task automatic send_gaps(input int count, input bit late_timeout);
        int          thr;
        int          tmo;
        logic [15:0] dur;
        thr = live_cfg.one_threshold_us;
        tmo = live_cfg.frame_timeout_us;
        for (int g = 0; g < count; g++)
        begin
            send_item(MODE_SEGMENT, 1'b1, dur_between(0, tmo - 1));
            // Now and then a tick or a dropped beat lands inside the frame.
            if ($urandom_range(29, 0) == 0)
                send_item($urandom_range(1, 0) ? MODE_TICK : MODE_UNUSED,
                          1'($urandom_range(1, 0)), 16'($urandom_range(65535, 0)));
            if (late_timeout && g == count - 1)
                dur = dur_between(tmo, 65535);
            else if (g == 0)
                dur = dur_between(0, tmo - 1);
            else if ($urandom_range(1, 0) == 1)
                dur = dur_between(thr + 1, tmo - 1);
            else
                dur = dur_between(0, (thr < tmo) ? thr : tmo - 1);
            send_item(MODE_SEGMENT, 1'b0, dur);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Waits until every predicted event has come out and the pipeline is
    // empty. The first wait lets the checker see the last accepted beat.
    task automatic settle();
        push <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: pop stalls at random per beat, with calm stretches in
    // between, and stays high while waiting for the next event.
    initial
    begin
        int stall;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(29, 0) == 0)
                drain_calm = !drain_calm;
            stall = drain_calm ? 0 : $urandom_range(11, 0);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
        end
    end

    initial
    begin
        int phase_start;
        int pick;
        int tmo;
        rst_n       <= 1'b0;
        push        <= 1'b0;
        mode        <= MODE_START;
        level       <= 1'b0;
        duration_us <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_KEY_MASK;
        cfg_data    <= '0;
        live_cfg.key_mask         = KEY_MASK_RST;
        live_cfg.one_threshold_us = ONE_THRESHOLD_RST;
        live_cfg.frame_timeout_us = FRAME_TIMEOUT_RST;
        live_cfg.release_delay_ms = RELEASE_DELAY_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset settings. Nothing is armed yet, so
        // the tick is ignored, and the segment falls outside any frame.
        send_item(MODE_TICK, 1'b0, 16'h0000);
        send_item(MODE_SEGMENT, 1'b0, 16'hFFFF);
        send_item(MODE_UNUSED, 1'b1, 16'hFFFF);
        // A frame start inside an open frame restarts it.
        send_item(MODE_START, 1'b1, 16'hFFFF);
        send_item(MODE_START, 1'b0, 16'h0000);
        send_item(MODE_SEGMENT, 1'b0, 16'h0000);
        // A mark one short of the timeout keeps the frame; the next one,
        // exactly at the timeout, ends it as a repeat and arms the release.
        send_item(MODE_SEGMENT, 1'b1, FRAME_TIMEOUT_RST - 16'd1);
        send_item(MODE_SEGMENT, 1'b1, FRAME_TIMEOUT_RST);
        send_ticks(2);
        // New frame while the release counts down; the countdown survives
        // until the long leader gap ends this frame early and rearms it.
        send_item(MODE_START, 1'b0, 16'h0000);
        send_item(MODE_SEGMENT, 1'b1, ONE_THRESHOLD_RST);
        send_item(MODE_SEGMENT, 1'b0, 16'hFFFF);
        send_item(MODE_SEGMENT, 1'b0, 16'h0000);
        send_item(MODE_TICK, 1'b1, 16'hFFFF);
        settle();

        // Random phases, each under its own register settings. The first few
        // phases take the extremes; the rest draw sensible random values.
        for (int phase = 1; sent_items < ITEM_TARGET; phase++)
        begin
            case (phase)
                1: live_cfg = '{16'hFFFF, ONE_THRESHOLD_RST, FRAME_TIMEOUT_RST, 8'd3};
                2: live_cfg = '{16'h0000, 16'd0, 16'hFFFF, 8'd1};
                3: live_cfg = '{16'($urandom), 16'hFFFF, 16'hFFFF, 8'd255};
                4: live_cfg = '{16'($urandom), 16'd500, 16'd3000, 8'd0};
                5: live_cfg = '{16'h5A5A, ONE_THRESHOLD_RST, 16'd0, 8'd2};
                default:
                begin
                    live_cfg.key_mask         = 16'($urandom);
                    live_cfg.one_threshold_us = 16'($urandom_range(3000, 200));
                    live_cfg.frame_timeout_us = live_cfg.one_threshold_us
                                                + 16'($urandom_range(8000, 1));
                    live_cfg.release_delay_ms = 8'($urandom_range(12, 1));
                end
            endcase
            write_reg(CFG_KEY_MASK, live_cfg.key_mask);
            write_reg(CFG_ONE_THRESHOLD, live_cfg.one_threshold_us);
            write_reg(CFG_FRAME_TIMEOUT, live_cfg.frame_timeout_us);
            write_reg(CFG_RELEASE_DELAY, {8'h00, live_cfg.release_delay_ms});
            cfg_valid <= 1'b0;

            tmo         = live_cfg.frame_timeout_us;
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS && sent_items < ITEM_TARGET)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 45)
                begin
                    // Complete frame; sometimes the last gap also times out.
                    send_item(MODE_START, 1'($urandom_range(1, 0)),
                              16'($urandom_range(65535, 0)));
                    send_gaps(32, $urandom_range(5, 0) == 0);
                    if ($urandom_range(1, 0) == 1)
                        send_ticks(live_cfg.release_delay_ms + $urandom_range(2, 0));
                end
                else if (pick < 60)
                begin
                    // Repeat code: leader gap, then a mark past the timeout.
                    send_item(MODE_START, 1'b0, 16'($urandom_range(65535, 0)));
                    send_item(MODE_SEGMENT, 1'b0, dur_between(0, tmo - 1));
                    send_item(MODE_SEGMENT, 1'b1, dur_between(tmo, 65535));
                    if ($urandom_range(1, 0) == 1)
                        send_ticks(live_cfg.release_delay_ms + $urandom_range(2, 0));
                end
                else if (pick < 75)
                begin
                    // Broken frame: cut short by a timeout, a restart, or
                    // simply left open.
                    send_item(MODE_START, 1'b1, 16'($urandom_range(65535, 0)));
                    send_gaps($urandom_range(24, 1), 1'b0);
                    case ($urandom_range(2, 0))
                        0: send_item(MODE_SEGMENT, 1'($urandom_range(1, 0)),
                                     dur_between(tmo, 65535));
                        1: send_item(MODE_START, 1'b0, 16'($urandom_range(65535, 0)));
                        default:
                        begin
                        end
                    endcase
                end
                else if (pick < 90)
                begin
                    send_ticks($urandom_range(live_cfg.release_delay_ms + 3, 1));
                end
                else
                begin
                    // Noise: any mode, any level, any duration.
                    repeat ($urandom_range(4, 1))
                        send_item(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)),
                                  16'($urandom_range(65535, 0)));
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("tb_nec_ir_pulse_distance_decoder_unit OK");
        else
            $display("tb_nec_ir_pulse_distance_decoder_unit NOT OK");
        $finish;
    end

endmodule
